/* rtl/hcbp_pkg.sv */
// Shared definitions for the Huffman code bit packer: item kinds and table sizes.
// No dependencies. Imported by huffman_code_bit_packer, hcbp_checker and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    // Kind of an input item, carried on s_tuser.
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    localparam int unsigned MAX_CODE_LEN_DEF = 32;
    localparam int unsigned NUM_SYMBOLS      = 256;
    localparam int unsigned SYM_W            = $clog2(NUM_SYMBOLS);

    // Fixed widths of the stream fields.
    localparam int unsigned CODEWORD_W = 32;
    localparam int unsigned CODELEN_W  = 6;
    localparam int unsigned BYTE_W     = 8;

endpackage : hcbp_pkg

`default_nettype wire

/* rtl/huffman_code_bit_packer.sv */
// Top level of the Huffman code bit packer: code table lookup and byte packing.
// Depends on hcbp_pkg and hcbp_ram.
//
//   Port group   Dir  tdata (low bit up)                          tuser / tlast
//   s_*          in   symbol[7:0], codeword[39:8], length[45:40]  tuser = func
//   m_*          out  out_byte[7:0]                               tlast = last of item
//
// An item enters the table read stage on the cycle it is accepted; the looked-up
// code is merged behind the pending bits once fewer than eight of them remain,
// and bytes leave one per cycle through the output register while m_tready is high.
// Load and unused items do not enter the lookup stage. Reset clears the pending
// bits; the code table is not cleared. A stalled output holds the packer and,
// through it, the input.
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer #(
    parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                                                   clk,
    input  wire logic                                                   rst_n,
    input  wire logic                                                   s_tvalid,
    output logic                                                        s_tready,
    // symbol [7:0], codeword [39:8], code_length [45:40], zero [47:46]
    input  wire logic [47:0]                                            s_tdata,
    // func [1:0]
    input  wire logic [1:0]                                             s_tuser,
    output logic                                                        m_tvalid,
    input  wire logic                                                   m_tready,
    // out_byte [7:0]
    output logic [hcbp_pkg::BYTE_W-1:0]                                 m_tdata,
    output logic                                                        m_tlast
);

    import hcbp_pkg::*;

    localparam int unsigned LW  = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned W   = MAX_CODE_LEN + BYTE_W;
    localparam int unsigned CW  = $clog2(W);
    localparam int unsigned TW  = MAX_CODE_LEN + LW;

    // Input fields.
    logic [SYM_W-1:0]      in_symbol;
    logic [CODEWORD_W-1:0] in_codeword;
    logic [CODELEN_W-1:0]  in_length;
    logic                  in_xfer;

    assign in_symbol   = s_tdata[SYM_W-1:0];
    assign in_codeword = s_tdata[SYM_W +: CODEWORD_W];
    assign in_length   = s_tdata[SYM_W+CODEWORD_W +: CODELEN_W];
    assign in_xfer     = s_tvalid && s_tready;

    // Table entries are stored with the code already left-aligned, so that the
    // merge needs only a shift by the pending bit count.
    logic [LW-1:0]           load_len;
    logic [MAX_CODE_LEN-1:0] load_code;
    logic [TW-1:0]           tab_rdata;
    logic [MAX_CODE_LEN-1:0] tab_code;
    logic [LW-1:0]           tab_len;

    always_comb
    begin
        if (in_length > CODELEN_W'(MAX_CODE_LEN))
        begin
            load_len = LW'(MAX_CODE_LEN);
        end
        else
        begin
            load_len = LW'(in_length);
        end
        load_code = in_codeword[MAX_CODE_LEN-1:0] << (LW'(MAX_CODE_LEN) - load_len);
    end

    hcbp_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_SYMBOLS)
    ) u_code_table (
        .clk   (clk),
        .we    (in_xfer && (s_tuser == FUNC_LOAD)),
        .waddr (in_symbol),
        .wdata ({load_code, load_len}),
        .re    (in_xfer && (s_tuser == FUNC_ENCODE)),
        .raddr (in_symbol),
        .rdata (tab_rdata)
    );

    assign tab_code = tab_rdata[TW-1:LW];
    assign tab_len  = tab_rdata[LW-1:0];

    // Lookup stage: an encode or flush item waits here for the packer.
    logic s1_valid_reg, s1_valid_next;
    logic s1_flush_reg, s1_flush_next;
    logic s1_take;

    // Packer window: valid bits left-aligned, zeros below them.
    logic [W-1:0]  win_reg, win_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          emit;
    logic [W-1:0]  base_win;
    logic [CW-1:0] base_cnt;
    logic          base_low;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = (cnt_reg[CW-1:3] != '0) && out_free;
    assign base_win = emit ? (win_reg << BYTE_W) : win_reg;
    assign base_cnt = emit ? (cnt_reg - CW'(BYTE_W)) : cnt_reg;
    assign base_low = (base_cnt[CW-1:3] == '0);
    assign s1_take  = s1_valid_reg && base_low;
    assign s_tready = !s1_valid_reg || s1_take;

    always_comb
    begin
        win_next = base_win;
        cnt_next = base_cnt;
        if (s1_take)
        begin
            if (s1_flush_reg)
            begin
                // Pad the pending bits out to a full byte; the zeros are already there.
                if (base_cnt != '0)
                begin
                    cnt_next = CW'(BYTE_W);
                end
            end
            else
            begin
                win_next = base_win | ({tab_code, {BYTE_W{1'b0}}} >> base_cnt[2:0]);
                cnt_next = base_cnt + CW'(tab_len);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !s1_take;
        s1_flush_next = s1_flush_reg;
        if (in_xfer)
        begin
            s1_valid_next = (s_tuser == FUNC_ENCODE) || (s_tuser == FUNC_FLUSH);
            s1_flush_next = (s_tuser == FUNC_FLUSH);
        end
        out_valid_next = emit || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            win_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_flush_reg  <= s1_flush_next;
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A byte is the item's last when fewer than eight bits stay behind it.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= win_reg[W-1 -: BYTE_W];
            out_last_reg <= (cnt_reg[CW-1:3] == (CW-3)'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // The window never holds more than a full code plus seven pending bits.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(W - 1))
        else $error("packer bit count out of range");

    // An empty window carries no stray bits into the next byte.
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (win_reg == '0))
        else $error("empty packer window holds set bits");

    // While a non-final byte waits, the rest of that item is still in the window.
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (cnt_reg[CW-1:3] != '0))
        else $error("non-final byte with no further byte pending");

    // Input back-pressure only comes from a lookup item that the packer cannot take.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && !base_low))
        else $error("input stalled without a waiting lookup item");

endmodule : huffman_code_bit_packer

`default_nettype wire

/* rtl/hcbp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies. Used for the code table of huffman_code_bit_packer.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
    parameter int unsigned WIDTH = 38,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : hcbp_ram

`default_nettype wire

/* test/hcbp_checker.sv */
// Checker for the Huffman code bit packer: watches both stream ports, predicts the packed bytes.
// Depends on hcbp_pkg. Instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module hcbp_checker
    import hcbp_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast,
    output int               error_count,
    output int               bytes_outstanding
);

    typedef struct packed {
        logic [CODEWORD_W-1:0] word;
        logic [CODELEN_W-1:0]  len;
    } code_entry_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } packed_byte_t;

    code_entry_t  code_table [NUM_SYMBOLS];
    logic [7:0]   fill_byte;
    int           fill_bits;
    packed_byte_t expected_bytes [$];

    initial
    begin
        error_count       = 0;
        bytes_outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Appends the code bits, earliest bit first. Each completed byte is held back one
    // step so that the final byte of the transfer can be marked as last.
    task automatic pack_code(input code_entry_t ent);
        packed_byte_t held;
        logic         have_held;
        int           i;
        have_held = 1'b0;
        held      = '0;
        for (i = int'(ent.len) - 1; i >= 0; i--)
        begin
            fill_byte[7 - fill_bits] = ent.word[i];
            fill_bits++;
            if (fill_bits == 8)
            begin
                if (have_held)
                    expected_bytes.push_back(held);
                held      = '{data: fill_byte, last: 1'b0};
                have_held = 1'b1;
                fill_byte = '0;
                fill_bits = 0;
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_bytes.push_back(held);
        end
    endtask

    task automatic take_item();
        logic [SYM_W-1:0]      sym;
        logic [CODEWORD_W-1:0] cw;
        logic [CODELEN_W-1:0]  len;
        sym = s_tdata[7:0];
        cw  = s_tdata[39:8];
        len = s_tdata[45:40];
        case (s_tuser)
            FUNC_LOAD:
            begin
                if (len > MAX_CODE_LEN)
                    len = CODELEN_W'(MAX_CODE_LEN);
                code_table[sym] = '{word: cw, len: len};
            end
            FUNC_ENCODE:
                pack_code(code_table[sym]);
            FUNC_FLUSH:
            begin
                if (fill_bits != 0)
                begin
                    expected_bytes.push_back('{data: fill_byte, last: 1'b1});
                    fill_byte = '0;
                    fill_bits = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_byte();
        packed_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            report_mismatch($sformatf("byte 0x%02h (last %0b) with none expected",
                                      m_tdata, m_tlast));
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (m_tdata !== want.data)
                report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                          m_tdata, want.data));
            if (m_tlast !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b on byte 0x%02h",
                                          m_tlast, want.last, want.data));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_byte = '0;
            fill_bits = 0;
            expected_bytes.delete();
            bytes_outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_byte();
            if (s_tvalid && s_tready)
                take_item();
            bytes_outstanding <= expected_bytes.size();
        end
    end

endmodule : hcbp_checker

/* test/tb_top.sv */
// Testbench top for the Huffman code bit packer: clock, reset, stimulus and verdict.
// Depends on hcbp_pkg, huffman_code_bit_packer and hcbp_checker.
`timescale 1ns / 1ps

module tb_top;
    import hcbp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED     = 2'd3;
    localparam int         RUN_LIMIT       = 300000;
    localparam int         LONG_HOLD       = 120;
    localparam int         SETTLE_CYCLES   = 20;
    localparam int         ITEMS_PER_PHASE = 75;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int error_count;
    int bytes_outstanding;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;

    logic [SYM_W-1:0] loaded_syms [$];
    bit               sym_loaded  [NUM_SYMBOLS];

    huffman_code_bit_packer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    hcbp_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .error_count       (error_count),
        .bytes_outstanding (bytes_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output side. A long hold-off keeps tready low while the sender goes on offering
    // transfers, so that the packer fills up and back-pressures its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] sym,
                             input logic [31:0] cw, input logic [5:0] len);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, len, cw, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == FUNC_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_outstanding != 0)
            @(posedge clk);
    endtask

    // Only symbols already in the table are encoded, since an unwritten entry is undefined.
    task automatic send_random(output bit counted);
        int         pick;
        int         len_pick;
        logic [5:0] len;
        pick     = $urandom_range(99);
        len_pick = $urandom_range(99);
        counted  = 1'b1;
        if (len_pick < 5)
            len = 6'd0;
        else if (len_pick < 70)
            len = 6'($urandom_range(12, 1));
        else if (len_pick < 92)
            len = 6'($urandom_range(32, 13));
        else
            len = 6'($urandom_range(63, 33));
        if (pick < 22 || loaded_syms.size() == 0)
            send_item(FUNC_LOAD, 8'($urandom), $urandom, len);
        else if (pick < 82)
            send_item(FUNC_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                      $urandom, 6'($urandom));
        else if (pick < 95)
            send_item(FUNC_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        else
        begin
            send_item(FUNC_UNUSED, 8'($urandom), $urandom, 6'($urandom));
            counted = 1'b0;
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
        int sent;
        bit counted;
        sent         = 0;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        if (long_hold)
            hold_req++;
        while (sent < ITEMS_PER_PHASE)
        begin
            send_random(counted);
            if (counted)
                sent++;
        end
        // The sender pauses here until every byte predicted so far has come out.
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty flush and an unused kind must give nothing.
        send_item(FUNC_FLUSH, 8'h00, 32'h0, 6'h00);
        send_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(FUNC_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
        // Overlong lengths saturate to the maximum code length.
        send_item(FUNC_LOAD, 8'hFF, 32'h0000_0000, 6'd63);
        send_item(FUNC_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd0);
        // Bits above the code length must be ignored.
        send_item(FUNC_LOAD, 8'h02, 32'hFFFF_FFF5, 6'd3);
        send_item(FUNC_LOAD, 8'h03, 32'h0000_0001, 6'd1);
        send_item(FUNC_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd33);
        send_item(FUNC_ENCODE, 8'h01, $urandom, 6'($urandom));
        send_item(FUNC_ENCODE, 8'h02, $urandom, 6'($urandom));
        send_item(FUNC_FLUSH, 8'h00, 32'h0, 6'h00);
        send_item(FUNC_FLUSH, 8'h00, 32'h0, 6'h00);
        send_item(FUNC_ENCODE, 8'h00, $urandom, 6'($urandom));
        send_item(FUNC_ENCODE, 8'h02, $urandom, 6'($urandom));
        send_item(FUNC_ENCODE, 8'h00, $urandom, 6'($urandom));
        send_item(FUNC_ENCODE, 8'hFF, $urandom, 6'($urandom));
        send_item(FUNC_ENCODE, 8'h80, $urandom, 6'($urandom));
        repeat (5) send_item(FUNC_ENCODE, 8'h03, $urandom, 6'($urandom));
        send_item(FUNC_ENCODE, 8'h02, $urandom, 6'($urandom));
        send_item(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        wait_drained();

        run_phase(0, 0, 1'b1);
        run_phase(55, 0, 1'b0);
        run_phase(0, 55, 1'b0);
        run_phase(35, 35, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule : tb_top

/* huffman_code_bit_packer.f */
rtl/hcbp_pkg.sv
rtl/hcbp_ram.sv
rtl/huffman_code_bit_packer.sv
test/hcbp_checker.sv
test/tb_top.sv
